### rtl/core/fpa_pkg.sv
package fpa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  // quotient bits produced by the divider; larger quotients are caught up front
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DIV_CW = 66;

  typedef enum logic [3:0] {
    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GT, CMD_LT, CMD_GE, CMD_LE,
    CMD_EQ, CMD_NE, CMD_INC, CMD_DEC, CMD_MIN, CMD_MAX, CMD_FROM_INT, CMD_TO_INT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } st_e;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } out_t;

  // item state between the front end and the back end
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] res;
    logic        cmp;
    st_e         st;
    logic        neg;
    logic        div_z;
    logic        div_ovf;
    logic [63:0] prod;
    logic [32:0] num_lo;
    logic [31:0] den;
    logic [31:0] rem;
    logic [32:0] quo;
  } pipe_t;

  // saturate a 33-bit signed value to 32 bits; bit 32 of the return is overflow
  function automatic logic [32:0] clamp33(logic [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

### rtl/core/fpa_front.sv
module fpa_front import fpa_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  in_t   data_i,
  output logic  valid_o,
  output pipe_t data_o
);

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] res;
    logic        cmp;
    st_e         st;
    logic        neg;
    logic        div_z;
    logic        div_ovf;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] rem0;
    logic [32:0] num_lo;
  } dec_t;

  dec_t  dec_d, dec_q;
  logic  dec_vld_q;
  pipe_t mul_d, mul_q;
  logic  mul_vld_q;

  always_comb begin
    logic signed [31:0] a, b;
    logic [32:0] c;
    logic signed [63:0] fi;
    logic [DIV_CW-1:0] num_ext, den_ext;
    a = data_i.operand_a;
    b = data_i.operand_b;
    c = '0;
    fi = 64'(a) <<< FracBits;
    dec_d = '0;
    dec_d.cmd = cmd_e'(data_i.command);
    dec_d.st = ST_OK;
    dec_d.mag_a = a[31] ? 32'(-a) : a;
    dec_d.mag_b = b[31] ? 32'(-b) : b;
    dec_d.neg = a[31] ^ b[31];
    dec_d.div_z = (b == 0);
    num_ext = DIV_CW'(dec_d.mag_a) << FracBits;
    den_ext = DIV_CW'(dec_d.mag_b) << DIV_STEPS;
    dec_d.div_ovf = (num_ext >= den_ext);
    dec_d.rem0 = num_ext[64:33];
    dec_d.num_lo = num_ext[32:0];
    unique case (dec_d.cmd)
      CMD_ADD:      c = clamp33(33'(a) + 33'(b));
      CMD_SUB:      c = clamp33(33'(a) - 33'(b));
      CMD_INC:      c = clamp33(33'(a) + 33'sd1);
      CMD_DEC:      c = clamp33(33'(a) - 33'sd1);
      CMD_GT:       dec_d.cmp = (a > b);
      CMD_LT:       dec_d.cmp = (a < b);
      CMD_GE:       dec_d.cmp = (a >= b);
      CMD_LE:       dec_d.cmp = (a <= b);
      CMD_EQ:       dec_d.cmp = (a == b);
      CMD_NE:       dec_d.cmp = (a != b);
      CMD_MIN:      c = {1'b0, (a <= b) ? a : b};
      CMD_MAX:      c = {1'b0, (a >= b) ? a : b};
      CMD_FROM_INT: begin
        if (&fi[63:31] || ~|fi[63:31]) begin
          c = {1'b0, fi[31:0]};
        end else begin
          c = {1'b1, fi[63] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
      end
      CMD_TO_INT:   c = {1'b0, 32'(a >>> FracBits)};
      default:      c = '0;
    endcase
    dec_d.res = c[31:0];
    dec_d.st = c[32] ? ST_OVF : ST_OK;
  end

  always_comb begin
    mul_d = '0;
    mul_d.cmd = dec_q.cmd;
    mul_d.res = dec_q.res;
    mul_d.cmp = dec_q.cmp;
    mul_d.st = dec_q.st;
    mul_d.neg = dec_q.neg;
    mul_d.div_z = dec_q.div_z;
    mul_d.div_ovf = dec_q.div_ovf;
    mul_d.prod = 64'(dec_q.mag_a) * 64'(dec_q.mag_b);
    mul_d.num_lo = dec_q.num_lo;
    mul_d.den = dec_q.mag_b;
    mul_d.rem = dec_q.rem0;
    mul_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
    end else if (en_i) begin
      dec_vld_q <= valid_i;
      mul_vld_q <= dec_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
      mul_q <= mul_d;
    end
  end

  assign valid_o = mul_vld_q;
  assign data_o  = mul_q;

endmodule

### rtl/core/fpa_div_step.sv
module fpa_div_step import fpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pipe_t data_i,
  output logic  valid_o,
  output pipe_t data_o
);

  pipe_t data_d, data_q;
  logic  valid_q;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    logic [32:0] t;
    logic        ge;
    t = {data_i.rem, data_i.num_lo[32]};
    ge = (t >= {1'b0, data_i.den});
    data_d = data_i;
    data_d.rem = ge ? 32'(t - {1'b0, data_i.den}) : t[31:0];
    data_d.quo = {data_i.quo[31:0], ge};
    data_d.num_lo = {data_i.num_lo[31:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/core/fpa_back.sv
module fpa_back import fpa_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pipe_t data_i,
  output logic  valid_o,
  output out_t  data_o
);

  typedef struct packed {
    logic        arith;
    logic        neg;
    logic [63:0] mag;
    logic [31:0] res;
    logic        cmp;
    st_e         st;
  } rnd_t;

  rnd_t rnd_d, rnd_q;
  logic rnd_vld_q;
  out_t out_d, out_q;
  logic out_vld_q;

  always_comb begin
    logic rbit;
    rbit = ({data_i.rem, 1'b0} >= {1'b0, data_i.den});
    rnd_d.arith = 1'b0;
    rnd_d.neg = data_i.neg;
    rnd_d.mag = '0;
    rnd_d.res = data_i.res;
    rnd_d.cmp = data_i.cmp;
    rnd_d.st = data_i.st;
    if (data_i.cmd == CMD_MUL) begin
      rnd_d.arith = 1'b1;
      rnd_d.mag = (data_i.prod + (64'd1 << (FracBits - 1))) >> FracBits;
    end else if (data_i.cmd == CMD_DIV) begin
      if (data_i.div_z) begin
        rnd_d.res = '0;
        rnd_d.st = ST_DIVZ;
      end else begin
        rnd_d.arith = 1'b1;
        // quotient too large for the divider: force saturation
        rnd_d.mag = data_i.div_ovf ? '1 : 64'(data_i.quo) + 64'(rbit);
      end
    end
  end

  always_comb begin
    out_d.result_value = rnd_q.res;
    out_d.compare_true = rnd_q.cmp;
    out_d.status = rnd_q.st;
    if (rnd_q.arith) begin
      out_d.status = ST_OK;
      if (rnd_q.neg) begin
        if (rnd_q.mag > 64'h8000_0000) begin
          out_d.result_value = 32'sh8000_0000;
          out_d.status = ST_OVF;
        end else begin
          out_d.result_value = 32'(-rnd_q.mag);
        end
      end else begin
        if (rnd_q.mag > 64'h7FFF_FFFF) begin
          out_d.result_value = 32'sh7FFF_FFFF;
          out_d.status = ST_OVF;
        end else begin
          out_d.result_value = rnd_q.mag[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      rnd_vld_q <= valid_i;
      out_vld_q <= rnd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q <= rnd_d;
      out_q <= out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

### rtl/core/fixed_point_alu.sv
// Path from accepted item to result: decode, multiply, 33 divider steps, round,
//   saturate; every command takes the same path.
// Throughput: one item per cycle; the divider is fully unrolled, one bit per stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload regs are not reset.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // global advance: every stage moves unless a result waits at the output
  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage chain: index 0 is the front end output, DIV_STEPS the last divider stage
  logic  vld   [DIV_STEPS+1];
  pipe_t pipe  [DIV_STEPS+1];

  fpa_front #(.FracBits(FracBits)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (vld[0]),
    .data_o  (pipe[0])
  );

  // divider: one quotient bit per stage, other commands ride along
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fpa_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .data_i  (pipe[i]),
      .valid_o (vld[i+1]),
      .data_o  (pipe[i+1])
    );
  end

  // rounding of multiply and divide, then saturation into the output register
  fpa_back #(.FracBits(FracBits)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld[DIV_STEPS]),
    .data_i  (pipe[DIV_STEPS]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
